// File: src/assert_macros.svh
// Assertion macros used by the checker file, lcsa_checker.
// Standalone: expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset.
`define LCSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset.
`define LCSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/lcsa_pkg.sv
// Shared types and codes of the linked-cell string allocator.
// No dependencies.
package lcsa_pkg;

  localparam logic [1:0] OPC_ALLOC = 2'd0;
  localparam logic [1:0] OPC_FREE  = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;
  localparam logic [1:0] OPC_WRITE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_ACCEPT,
    CMD_BAD,
    CMD_WR,
    CMD_RD,
    CMD_F_STEP,
    CMD_F_END,
    CMD_R_TAKE,
    CMD_R_EMPTY,
    CMD_R_FIN_OK,
    CMD_R_FIN_TR,
    CMD_R_FIN_CHK,
    CMD_A_RD,
    CMD_A_FULL,
    CMD_A_W,
    CMD_A_N1,
    CMD_A_N2
  } cmd_t;

  typedef struct packed {
    logic       byte_zero;
    logic       link_oob;
    logic       head_oob;
    logic       addr_bad;
    logic       steps_lim;
    logic       count_zero;
    logic       count_hit;
    logic       out_free;
    logic       clr_last;
    logic [1:0] opcode;
    logic       last;
  } sts_t;

endpackage

// File: src/lcsa_in_if.sv
// Input item channel: valid/ready handshake plus the item fields.
// No dependencies.
interface lcsa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [9:0] address;
  logic [7:0] char_value;
  logic       last_char;
  modport source (output valid, opcode, address, char_value, last_char, input ready);
  modport sink   (input valid, opcode, address, char_value, last_char, output ready);
endinterface

// File: src/lcsa_out_if.sv
// Result item channel: valid/ready handshake plus the result fields.
// No dependencies.
interface lcsa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [10:0] cell_address;
  logic [7:0]  byte_out;
  logic        last_result;
  modport source (output valid, status, cell_address, byte_out, last_result, input ready);
  modport sink   (input valid, status, cell_address, byte_out, last_result, output ready);
endinterface

// File: src/linked_cell_string_allocator_top.sv
// Top level of the linked-cell string allocator.
// Depends on lcsa_pkg, lcsa_in_if, lcsa_out_if, lcsa_ctrl, lcsa_datapath.
//
// Usage: items enter on in_ch (alloc byte, free block, read block, write
// cell) and results leave on out_ch, both valid/ready. One item is worked
// at a time; in_ch.ready is high only when the controller is idle.
// After reset a clearing pass over all POOL_DEPTH cells loads the cell
// memories (bytes zero, links index plus one); no item is taken during it.
// Per item: a write or a bad address is answered at dispatch; an alloc
// reads the free-head link, then writes the cell, and the terminator cell
// too when the byte is the last; a free walks the chain cell by cell to its
// tail; a read walks it byte by byte, one result per byte, at most MAX_READ.
// A read keeps one byte pending so the last result can be marked; when the
// receiver stalls, the result register holds and the walk waits on it.
module linked_cell_string_allocator_top #(
  parameter int POOL_DEPTH = 1024,
  parameter int MAX_READ   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lcsa_in_if.sink     in_ch,
  lcsa_out_if.source  out_ch
);

  lcsa_pkg::cmd_t cmd;
  lcsa_pkg::sts_t sts;

  lcsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcsa_datapath #(
    .DEPTH    (POOL_DEPTH),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_ch.opcode),
    .in_address       (in_ch.address),
    .in_char_value    (in_ch.char_value),
    .in_last_char     (in_ch.last_char),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_cell_address (out_ch.cell_address),
    .out_byte_out     (out_ch.byte_out),
    .out_last_result  (out_ch.last_result)
  );

endmodule

// File: src/lcsa_datapath.sv
// Datapath: cell byte and link memories, list pointers, walk counters and
// the result register. Driven by commands from lcsa_ctrl; uses lcsa_pkg.
module lcsa_datapath #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lcsa_pkg::cmd_t   cmd,
  output lcsa_pkg::sts_t   sts,
  input  logic [1:0]       in_opcode,
  input  logic [9:0]       in_address,
  input  logic [7:0]       in_char_value,
  input  logic             in_last_char,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [10:0]      out_cell_address,
  output logic [7:0]       out_byte_out,
  output logic             out_last_result
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = $clog2(MAX_READ + 1);

  logic [7:0]    bytes_mem [DEPTH];
  logic [LW-1:0] links_mem [DEPTH];

  // Memory ports
  logic          wb_en, rb_en, wl_en, rl_en;
  logic [AW-1:0] wb_a, rb_a, wl_a, rl_a;
  logic [7:0]    wb_d;
  logic [LW-1:0] wl_d;
  logic [7:0]    brd_r;
  logic [LW-1:0] lrd_r;

  // Item and list state
  logic [1:0]    op_r;
  logic [9:0]    addr_r;
  logic [7:0]    ch_r;
  logic          last_r;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] pend_cell_r, pend_cell_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          open_r, open_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;

  // Result register
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [10:0]   out_cell_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          emit;
  logic [1:0]    e_status;
  logic [10:0]   e_cell;
  logic [7:0]    e_byte;
  logic          e_last;
  logic          link_oob;
  logic [AW-1:0] fh_idx, lrd_idx;

  assign link_oob = lrd_r >= LW'(DEPTH);
  assign fh_idx   = AW'(free_head_r);
  assign lrd_idx  = AW'(lrd_r);

  assign sts.byte_zero  = brd_r == 8'd0;
  assign sts.link_oob   = link_oob;
  assign sts.head_oob   = free_head_r >= LW'(DEPTH);
  assign sts.addr_bad   = {22'd0, addr_r} >= 32'(DEPTH);
  assign sts.steps_lim  = steps_r == LW'(DEPTH - 1);
  assign sts.count_zero = count_r == '0;
  assign sts.count_hit  = count_r == CW'(MAX_READ - 1);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.clr_last   = clr_idx_r == AW'(DEPTH - 1);
  assign sts.opcode     = op_r;
  assign sts.last       = last_r;

  always_comb begin
    wb_en = 1'b0; wb_a = cur_r; wb_d = 8'd0;
    rb_en = 1'b0; rb_a = cur_r;
    wl_en = 1'b0; wl_a = cur_r; wl_d = free_head_r;
    rl_en = 1'b0; rl_a = cur_r;
    emit = 1'b0; e_status = lcsa_pkg::ST_OK; e_cell = 11'(addr_r);
    e_byte = 8'd0; e_last = 1'b1;
    cur_nxt = cur_r; steps_nxt = steps_r; count_nxt = count_r;
    pend_cell_nxt = pend_cell_r; pend_byte_nxt = pend_byte_r;
    free_head_nxt = free_head_r; start_nxt = start_r; tail_nxt = tail_r;
    open_nxt = open_r; clr_idx_nxt = clr_idx_r;
    unique case (cmd)
      lcsa_pkg::CMD_CLR: begin
        wb_en = 1'b1; wb_a = clr_idx_r;
        wl_en = 1'b1; wl_a = clr_idx_r; wl_d = LW'(clr_idx_r) + LW'(1);
        clr_idx_nxt = clr_idx_r + AW'(1);
      end
      lcsa_pkg::CMD_ACCEPT: begin
        cur_nxt = AW'(in_address); steps_nxt = '0; count_nxt = '0;
      end
      lcsa_pkg::CMD_BAD: begin
        emit = 1'b1; e_status = lcsa_pkg::ST_BAD;
      end
      lcsa_pkg::CMD_WR: begin
        wb_en = 1'b1; wb_d = ch_r; emit = 1'b1;
      end
      lcsa_pkg::CMD_RD: begin
        rb_en = 1'b1; rl_en = 1'b1;
      end
      lcsa_pkg::CMD_F_STEP: begin
        wb_en = 1'b1;
        steps_nxt = steps_r + LW'(1);
        cur_nxt = lrd_idx;
        rb_en = 1'b1; rb_a = lrd_idx; rl_en = 1'b1; rl_a = lrd_idx;
      end
      lcsa_pkg::CMD_F_END: begin
        // close the chain onto the old free head
        wb_en = 1'b1; wl_en = 1'b1;
        free_head_nxt = LW'(addr_r);
        emit = 1'b1;
      end
      lcsa_pkg::CMD_R_TAKE: begin
        emit = !sts.count_zero; e_cell = 11'(pend_cell_r); e_byte = pend_byte_r;
        e_last = 1'b0;
        pend_cell_nxt = cur_r; pend_byte_nxt = brd_r;
        count_nxt = count_r + CW'(1);
        cur_nxt = lrd_idx;
        rb_en = !link_oob; rb_a = lrd_idx; rl_en = !link_oob; rl_a = lrd_idx;
      end
      lcsa_pkg::CMD_R_EMPTY: emit = 1'b1;
      lcsa_pkg::CMD_R_FIN_OK, lcsa_pkg::CMD_R_FIN_TR, lcsa_pkg::CMD_R_FIN_CHK: begin
        emit = 1'b1; e_cell = 11'(pend_cell_r); e_byte = pend_byte_r;
        if (cmd == lcsa_pkg::CMD_R_FIN_TR ||
            (cmd == lcsa_pkg::CMD_R_FIN_CHK && brd_r != 8'd0)) begin
          e_status = lcsa_pkg::ST_TRUNC;
        end
      end
      lcsa_pkg::CMD_A_RD: begin
        rl_en = 1'b1; rl_a = fh_idx;
      end
      lcsa_pkg::CMD_A_FULL: begin
        emit = 1'b1; e_status = lcsa_pkg::ST_FULL;
        e_cell = open_r ? 11'(start_r) : 11'(free_head_r);
        open_nxt = 1'b0;
      end
      lcsa_pkg::CMD_A_W: begin
        wb_en = 1'b1; wb_a = fh_idx; wb_d = ch_r;
        wl_en = open_r; wl_a = tail_r; wl_d = free_head_r;
        rl_en = 1'b1; rl_a = fh_idx;
        if (!open_r) begin
          start_nxt = fh_idx;
          open_nxt = 1'b1;
        end
        tail_nxt = fh_idx;
      end
      lcsa_pkg::CMD_A_N1: begin
        free_head_nxt = lrd_r;
        if (last_r) begin
          wb_en = 1'b1; wb_a = lrd_idx;
          rl_en = 1'b1; rl_a = lrd_idx;
        end else begin
          emit = 1'b1; e_cell = 11'(start_r);
        end
      end
      lcsa_pkg::CMD_A_N2: begin
        free_head_nxt = lrd_r; open_nxt = 1'b0;
        emit = 1'b1; e_cell = 11'(start_r);
      end
      default: ;
    endcase
  end

  // Memories, with write-to-read bypass so a same-cycle write is seen
  always_ff @(posedge clk) begin
    if (wb_en) bytes_mem[wb_a] <= wb_d;
    if (rb_en) brd_r <= (wb_en && wb_a == rb_a) ? wb_d : bytes_mem[rb_a];
    if (wl_en) links_mem[wl_a] <= wl_d;
    if (rl_en) lrd_r <= (wl_en && wl_a == rl_a) ? wl_d : links_mem[rl_a];
  end

  always_ff @(posedge clk) begin
    if (cmd == lcsa_pkg::CMD_ACCEPT) begin
      op_r <= in_opcode; addr_r <= in_address;
      ch_r <= in_char_value; last_r <= in_last_char;
    end
    cur_r <= cur_nxt; steps_r <= steps_nxt; count_r <= count_nxt;
    pend_cell_r <= pend_cell_nxt; pend_byte_r <= pend_byte_nxt;
    if (emit) begin
      out_status_r <= e_status; out_cell_r <= e_cell;
      out_byte_r <= e_byte; out_last_r <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0; start_r <= '0; tail_r <= '0; open_r <= 1'b0;
      clr_idx_r <= '0; out_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt; start_r <= start_nxt; tail_r <= tail_nxt;
      open_r <= open_nxt; clr_idx_r <= clr_idx_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_cell_address = out_cell_r;
  assign out_byte_out     = out_byte_r;
  assign out_last_result  = out_last_r;

endmodule

// File: src/lcsa_ctrl.sv
// Controller: sequences the clearing pass and each operation as datapath
// commands. Uses lcsa_pkg.
module lcsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lcsa_pkg::sts_t sts,
  output lcsa_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_A_CHK, S_A_N1, S_A_N2,
    S_F_EV, S_R_EV, S_R_TR, S_R_CHK
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd = lcsa_pkg::CMD_NONE;
    unique case (state_r)
      S_CLR: begin
        cmd = lcsa_pkg::CMD_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = lcsa_pkg::CMD_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.opcode == lcsa_pkg::OPC_ALLOC) begin
          if (!sts.head_oob) begin
            cmd = lcsa_pkg::CMD_A_RD; state_nxt = S_A_CHK;
          end else if (sts.out_free) begin
            cmd = lcsa_pkg::CMD_A_FULL; state_nxt = S_IDLE;
          end
        end else if (sts.addr_bad) begin
          if (sts.out_free) begin
            cmd = lcsa_pkg::CMD_BAD; state_nxt = S_IDLE;
          end
        end else if (sts.opcode == lcsa_pkg::OPC_WRITE) begin
          if (sts.out_free) begin
            cmd = lcsa_pkg::CMD_WR; state_nxt = S_IDLE;
          end
        end else begin
          cmd = lcsa_pkg::CMD_RD;
          state_nxt = (sts.opcode == lcsa_pkg::OPC_FREE) ? S_F_EV : S_R_EV;
        end
      end
      S_A_CHK: begin
        // terminator needs a second free cell
        if (sts.last && sts.link_oob) begin
          if (sts.out_free) begin
            cmd = lcsa_pkg::CMD_A_FULL; state_nxt = S_IDLE;
          end
        end else begin
          cmd = lcsa_pkg::CMD_A_W; state_nxt = S_A_N1;
        end
      end
      S_A_N1: begin
        if (sts.last) begin
          cmd = lcsa_pkg::CMD_A_N1; state_nxt = S_A_N2;
        end else if (sts.out_free) begin
          cmd = lcsa_pkg::CMD_A_N1; state_nxt = S_IDLE;
        end
      end
      S_A_N2: begin
        if (sts.out_free) begin
          cmd = lcsa_pkg::CMD_A_N2; state_nxt = S_IDLE;
        end
      end
      S_F_EV: begin
        if (sts.byte_zero || sts.link_oob || sts.steps_lim) begin
          if (sts.out_free) begin
            cmd = lcsa_pkg::CMD_F_END; state_nxt = S_IDLE;
          end
        end else begin
          cmd = lcsa_pkg::CMD_F_STEP;
        end
      end
      S_R_EV: begin
        if (sts.byte_zero) begin
          if (sts.out_free) begin
            cmd = sts.count_zero ? lcsa_pkg::CMD_R_EMPTY : lcsa_pkg::CMD_R_FIN_OK;
            state_nxt = S_IDLE;
          end
        end else if (sts.count_zero || sts.out_free) begin
          cmd = lcsa_pkg::CMD_R_TAKE;
          if (sts.link_oob) state_nxt = S_R_TR;
          else if (sts.count_hit) state_nxt = S_R_CHK;
        end
      end
      S_R_TR: begin
        if (sts.out_free) begin
          cmd = lcsa_pkg::CMD_R_FIN_TR; state_nxt = S_IDLE;
        end
      end
      S_R_CHK: begin
        if (sts.out_free) begin
          cmd = lcsa_pkg::CMD_R_FIN_CHK; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

endmodule

// File: src/lcsa_checker.sv
// Port-level checks of the allocator top, bound onto every instance.
// Depends on lcsa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lcsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_byte_out,
  input logic        out_last_result
);

  `LCSA_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
  `LCSA_ASSERT_IMP(a_err_last,
    out_valid && (out_status == lcsa_pkg::ST_FULL || out_status == lcsa_pkg::ST_BAD),
    out_last_result, "error result not final")
  `LCSA_ASSERT_IMP(a_byte_read, out_valid && out_byte_out != 8'd0,
    out_status == lcsa_pkg::ST_OK || out_status == lcsa_pkg::ST_TRUNC,
    "byte on non-read result")
  `LCSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule

bind linked_cell_string_allocator_top lcsa_checker u_lcsa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_byte_out    (out_ch.byte_out),
  .out_last_result (out_ch.last_result)
);
